>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the wakeup queue.
// Included by modules that check their own behavior; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on each rising clock edge, idle during reset.
`define ASSERT_PROP(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// Checks that an expression is never true on a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(name, clk, rstn, prop)
`define ASSERT_NEVER(name, clk, rstn, expr)

`endif

`endif

>>> hw/rtl/dtwq_pkg.sv
// Types and constants of the delayed task wakeup queue.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package dtwq_pkg;

  localparam int KIND_W = 2;
  localparam int TASK_W = 5;
  localparam int DL_W = 32;
  localparam int NOW_W = 31;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [NOW_W-1:0] NOW_MAX = {NOW_W{1'b1}};
  localparam logic signed [DL_W-1:0] DL_MAX = {1'b0, {(DL_W - 1){1'b1}}};
  localparam logic signed [DL_W-1:0] DL_MIN = {1'b1, {(DL_W - 1){1'b0}}};

  typedef enum logic [KIND_W-1:0] {
    KIND_QUERY = 2'd0,
    KIND_REL   = 2'd1,
    KIND_ABS   = 2'd2,
    KIND_TICK  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_TICK,
    ST_REMOVE,
    ST_INSERT,
    ST_RELEASE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic tick;
    logic remove;
    logic insert;
    logic emit_query;
    logic emit_wake;
    logic last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e in_kind;
    logic  in_task_ok;
    logic  head_due;
    logic  next_due;
    logic  out_free;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/delayed_task_wakeup_queue_core.sv
// Top level of the delayed task wakeup queue.
// Depends on dtwq_pkg, dtwq_ctrl, dtwq_datapath and assert_macros.svh.
//
// The block keeps a tick counter and a queue of sleeping tasks sorted by wake
// deadline. Input items arrive on the in_valid_i/in_stall_o channel: a time
// query, a relative delay, an absolute delay or a timer tick. Results leave on
// the out_valid_o/out_stall_i channel, one item per result, and last_o marks
// the final result caused by an input item. A tick or delay that wakes no task
// gives no result at all.
// An input item is worked on alone: after it is accepted the input stays
// stalled while the sequencer goes through ST_QUERY (time query), ST_TICK
// (tick) or ST_REMOVE and ST_INSERT (delay, unless from a task beyond the
// slots) and then ST_RELEASE, which writes the first result unless ST_QUERY
// did. It waits while a result waits on the receiver and else does one queue
// operation per cycle (remove, insert or pop of the head). At most 32 results
// come from one item; due tasks left over go out with the next item.
// When the receiver stalls, the output register holds its result and the
// sequencer waits with the next one; after the last result of an item, the
// sequencer passes ST_RELEASE to ST_IDLE, where the next item can be accepted.
// Reset clears the tick count to zero and empties the queue; no result is
// pending after reset and the block is ready for input at once.
`default_nettype none

`include "assert_macros.svh"

module delayed_task_wakeup_queue_core import dtwq_pkg::*; #(
  parameter int TASK_SLOTS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [KIND_W-1:0]      kind_i,
  input  wire logic [TASK_W-1:0]      task_id_i,
  input  wire logic signed [DL_W-1:0] tick_amount_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        result_kind_o,
  output logic [TASK_W-1:0]           target_task_o,
  output logic [NOW_W-1:0]            time_value_o,
  output logic                        last_o
);

  cmd_t    cmd;
  status_t status;

  dtwq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dtwq_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .task_id_i     (task_id_i),
    .tick_amount_i (tick_amount_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .result_kind_o (result_kind_o),
    .target_task_o (target_task_o),
    .time_value_o  (time_value_o),
    .last_o        (last_o)
  );

  // The sequencer is busy in the cycle after it takes an item.
  `ASSERT_PROP(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)

  // A new item is only taken once the pending result closes the previous one.
  `ASSERT_PROP(a_accept_after_last, clk_i, rst_ni, (in_valid_i && !in_stall_o && out_valid_o) |-> last_o)

  // The sequencer issues at most one datapath operation per cycle.
  `ASSERT_PROP(a_one_cmd, clk_i, rst_ni, $onehot0({cmd.load_item, cmd.tick, cmd.remove, cmd.insert, cmd.emit_query, cmd.emit_wake}))

endmodule

`default_nettype wire

>>> hw/rtl/dtwq_ctrl.sv
// Sequencer of the delayed task wakeup queue.
// Depends on dtwq_pkg; drives the datapath through cmd_t and reads status_t.
`default_nettype none

module dtwq_ctrl import dtwq_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic room;
  logic room_after;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  assign room       = (count_q < CNT_W'(MAX_RESULTS));
  assign room_after = (count_q < CNT_W'(MAX_RESULTS - 1));
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          count_d = '0;
          case (status_i.in_kind)
            KIND_QUERY: state_d = ST_QUERY;
            KIND_REL, KIND_ABS: state_d = status_i.in_task_ok ? ST_REMOVE : ST_RELEASE;
            KIND_TICK: state_d = ST_TICK;
            default: state_d = ST_RELEASE;
          endcase
        end
      end
      ST_QUERY: begin
        if (status_i.out_free) begin
          cmd_o.emit_query = 1'b1;
          cmd_o.last = !(status_i.head_due && room_after);
          count_d = count_q + CNT_W'(1);
          state_d = ST_RELEASE;
        end
      end
      ST_TICK: begin
        cmd_o.tick = 1'b1;
        state_d = ST_RELEASE;
      end
      ST_REMOVE: begin
        cmd_o.remove = 1'b1;
        state_d = ST_INSERT;
      end
      ST_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d = ST_RELEASE;
      end
      ST_RELEASE: begin
        if (status_i.head_due && room) begin
          if (status_i.out_free) begin
            cmd_o.emit_wake = 1'b1;
            cmd_o.last = !(status_i.next_due && room_after);
            count_d = count_q + CNT_W'(1);
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/dtwq_datapath.sv
// Datapath of the delayed task wakeup queue: tick counter, sorted row of
// queue cells and the result register. Depends on dtwq_pkg.
`default_nettype none

module dtwq_datapath import dtwq_pkg::*; #(
  parameter int TASK_SLOTS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [KIND_W-1:0]      kind_i,
  input  wire logic [TASK_W-1:0]      task_id_i,
  input  wire logic signed [DL_W-1:0] tick_amount_i,
  input  wire cmd_t                   cmd_i,
  output status_t                     status_o,
  input  wire logic                   out_stall_i,
  output logic                        out_valid_o,
  output logic                        result_kind_o,
  output logic [TASK_W-1:0]           target_task_o,
  output logic [NOW_W-1:0]            time_value_o,
  output logic                        last_o
);

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  logic [NOW_W-1:0] now_q, now_d;
  logic [TASK_W-1:0] item_task_q;
  logic signed [DL_W-1:0] item_dl_q, item_dl_d;
  logic signed [DL_W-1:0] now_s;
  logic signed [DL_W+1:0] rel_sum;

  // Queue cells, kept sorted by deadline with older entries first on ties.
  logic [TASK_SLOTS-1:0] valid_q, valid_d;
  logic signed [DL_W-1:0] dl_q [TASK_SLOTS];
  logic signed [DL_W-1:0] dl_d [TASK_SLOTS];
  logic [TASK_W-1:0] tid_q [TASK_SLOTS];
  logic [TASK_W-1:0] tid_d [TASK_SLOTS];

  logic [TASK_SLOTS-1:0] match;
  logic [TASK_SLOTS-1:0] le;
  logic [SLOT_W-1:0] rm_pos;
  logic any_match;

  logic out_valid_q;
  logic result_kind_q;
  logic [TASK_W-1:0] target_task_q;
  logic [NOW_W-1:0] time_value_q;
  logic last_q;
  logic out_free;
  logic emit;

  assign now_s = $signed({1'b0, now_q});

  // Relative deadline with saturation to the signed 32-bit range.
  assign rel_sum = $signed({3'b000, now_q}) + $signed({{2{tick_amount_i[DL_W-1]}}, tick_amount_i});

  always_comb begin
    if (kind_i == KIND_REL) begin
      if (rel_sum[DL_W+1:DL_W-1] == 3'b000 || rel_sum[DL_W+1:DL_W-1] == 3'b111) begin
        item_dl_d = rel_sum[DL_W-1:0];
      end else begin
        item_dl_d = rel_sum[DL_W+1] ? DL_MIN : DL_MAX;
      end
    end else begin
      item_dl_d = tick_amount_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_task_q <= task_id_i;
      item_dl_q   <= item_dl_d;
    end
  end

  always_comb begin
    now_d = now_q;
    if (cmd_i.tick && now_q != NOW_MAX) begin
      now_d = now_q + NOW_W'(1);
    end
  end

  always_comb begin
    rm_pos = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      match[i] = valid_q[i] && (tid_q[i] == item_task_q);
      le[i]    = valid_q[i] && (dl_q[i] <= item_dl_q);
      if (match[i]) begin
        rm_pos = rm_pos | SLOT_W'(i);
      end
    end
    any_match = |match;
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = cmd_i.emit_query || cmd_i.emit_wake;

  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      dl_d[i]  = dl_q[i];
      tid_d[i] = tid_q[i];
    end
    if (cmd_i.remove && any_match) begin
      // Close the gap left by the replaced entry.
      for (int i = 0; i < TASK_SLOTS - 1; i++) begin
        if (SLOT_W'(i) >= rm_pos) begin
          valid_d[i] = valid_q[i+1];
          dl_d[i]    = dl_q[i+1];
          tid_d[i]   = tid_q[i+1];
        end
      end
      valid_d[TASK_SLOTS-1] = 1'b0;
    end else if (cmd_i.insert) begin
      // New entry goes behind every entry due no later than it.
      if (!le[0]) begin
        valid_d[0] = 1'b1;
        dl_d[0]    = item_dl_q;
        tid_d[0]   = item_task_q;
      end
      for (int i = 1; i < TASK_SLOTS; i++) begin
        if (!le[i]) begin
          if (le[i-1]) begin
            valid_d[i] = 1'b1;
            dl_d[i]    = item_dl_q;
            tid_d[i]   = item_task_q;
          end else begin
            valid_d[i] = valid_q[i-1];
            dl_d[i]    = dl_q[i-1];
            tid_d[i]   = tid_q[i-1];
          end
        end
      end
    end else if (cmd_i.emit_wake) begin
      for (int i = 0; i < TASK_SLOTS - 1; i++) begin
        valid_d[i] = valid_q[i+1];
        dl_d[i]    = dl_q[i+1];
        tid_d[i]   = tid_q[i+1];
      end
      valid_d[TASK_SLOTS-1] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      now_q   <= now_d;
      valid_q <= valid_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      dl_q[i]  <= dl_d[i];
      tid_q[i] <= tid_d[i];
    end
    if (emit) begin
      result_kind_q <= cmd_i.emit_wake;
      target_task_q <= cmd_i.emit_wake ? tid_q[0] : item_task_q;
      time_value_q  <= now_q;
      last_q        <= cmd_i.last;
    end
  end

  assign status_o.in_kind    = kind_e'(kind_i);
  assign status_o.in_task_ok = ({{(32 - TASK_W){1'b0}}, task_id_i} < 32'(TASK_SLOTS));
  assign status_o.head_due   = valid_q[0] && (dl_q[0] <= now_s);
  assign status_o.next_due   = valid_q[1] && (dl_q[1] <= now_s);
  assign status_o.out_free   = out_free;

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = result_kind_q;
  assign target_task_o = target_task_q;
  assign time_value_o  = time_value_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

>>> tb/delayed_task_wakeup_queue_core_test.sv
// Self-checking testbench of delayed_task_wakeup_queue_core.
// It holds a scoreboard class that predicts the results of every accepted item.
// It depends on dtwq_pkg and on the RTL of the block.
`default_nettype none

module delayed_task_wakeup_queue_core_test import dtwq_pkg::*;;

  localparam int SLOTS = 32;
  // The run ends with a failure when this many cycles have passed.
  localparam int CYCLE_LIMIT = 400000;
  // This is how long the receiver holds off while the queue is being filled.
  localparam int HOLD_CYCLES = 300;
  // These are the settling cycles after the last expected result has come.
  localparam int TAIL_CYCLES = 40;
  localparam int DRAIN_LIMIT = 20000;

  // One result of the block as the scoreboard predicts it.
  typedef struct {
    logic             kind;
    logic [TASK_W-1:0] target;
    logic [NOW_W-1:0] stamp;
    logic             last;
  } wake_result_t;

  // The scoreboard keeps its own copy of the tick count and of the sleeping
  // tasks. It turns each accepted item into the results that the block owes.
  class wakeup_scoreboard;
    logic [NOW_W-1:0]       now_count;
    logic signed [DL_W-1:0] slot_deadline [SLOTS];
    logic                   slot_asleep [SLOTS];
    logic [5:0]             slot_rank [SLOTS];
    wake_result_t           awaited [$];
    int                     errors;

    function new();
      now_count = '0;
      errors = 0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_asleep[i] = 1'b0;
        slot_deadline[i] = '0;
        slot_rank[i] = '0;
      end
    endfunction

    function int count();
      return awaited.size();
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    // A task leaves the queue, and every younger entry moves up one rank.
    function void drop_slot(int s);
      if (!slot_asleep[s]) return;
      slot_asleep[s] = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_asleep[i] && slot_rank[i] > slot_rank[s]) slot_rank[i] = slot_rank[i] - 6'd1;
      end
    endfunction

    // A repeat request replaces the old entry, and the new entry ranks as the newest.
    function void park_slot(int s, logic signed [DL_W+1:0] dl);
      int asleep_count;
      asleep_count = 0;
      drop_slot(s);
      if (dl > DL_MAX) dl = DL_MAX;
      if (dl < DL_MIN) dl = DL_MIN;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_asleep[i]) asleep_count++;
      end
      slot_deadline[s] = dl[DL_W-1:0];
      slot_rank[s] = 6'(asleep_count);
      slot_asleep[s] = 1'b1;
    endfunction

    function void note_item(kind_e kind, logic [TASK_W-1:0] tid, logic signed [DL_W-1:0] amount);
      logic signed [DL_W+1:0] dl;
      int made;
      int best;
      made = 0;
      case (kind)
        KIND_QUERY: begin
          awaited.push_back('{1'b0, tid, now_count, 1'b0});
          made++;
        end
        KIND_REL: begin
          if (int'(tid) < SLOTS) begin
            dl = $signed({3'b000, now_count}) + amount;
            park_slot(int'(tid), dl);
          end
        end
        KIND_ABS: begin
          if (int'(tid) < SLOTS) begin
            dl = amount;
            park_slot(int'(tid), dl);
          end
        end
        default: begin
          if (now_count != NOW_MAX) now_count = now_count + 1'b1;
        end
      endcase
      // Due tasks go out by deadline and then by age, up to the per-item cap.
      while (made < MAX_RESULTS) begin
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_asleep[i] || slot_deadline[i] > $signed({1'b0, now_count})) continue;
          if (best < 0 || slot_deadline[i] < slot_deadline[best] ||
              (slot_deadline[i] == slot_deadline[best] && slot_rank[i] < slot_rank[best]))
            best = i;
        end
        if (best < 0) break;
        drop_slot(best);
        awaited.push_back('{1'b1, TASK_W'(best), now_count, 1'b0});
        made++;
      end
      if (made > 0) awaited[$].last = 1'b1;
    endfunction

    task check_result(logic kind, logic [TASK_W-1:0] target, logic [NOW_W-1:0] stamp,
                      logic last);
      wake_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result kind %0d task %0d time %0d came with nothing awaited",
                         kind, target, stamp));
        return;
      end
      want = awaited.pop_front();
      if (kind !== want.kind)
        report($sformatf("result_kind %0d, predicted %0d", kind, want.kind));
      if (target !== want.target)
        report($sformatf("target_task %0d, predicted %0d", target, want.target));
      if (stamp !== want.stamp)
        report($sformatf("time_value %0d, predicted %0d", stamp, want.stamp));
      if (last !== want.last)
        report($sformatf("last %0d, predicted %0d (task %0d)", last, want.last, want.target));
    endtask

    task close();
      if (awaited.size() != 0)
        report($sformatf("%0d predicted results never came", awaited.size()));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [KIND_W-1:0]      in_kind = '0;
  logic [TASK_W-1:0]      in_task = '0;
  logic signed [DL_W-1:0] in_amount = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   res_kind;
  logic [TASK_W-1:0]      res_task;
  logic [NOW_W-1:0]       res_time;
  logic                   res_last;

  // This is the chance in percent that the sender idles in a given cycle.
  int idle_pct = 11;
  // This is the chance in percent that the receiver stalls in a given cycle.
  int stall_pct = 58;
  // While this is set, the receiver stalls without a break.
  logic hold_off = 1'b0;
  int cycles = 0;

  wakeup_scoreboard tracker = new();

  delayed_task_wakeup_queue_core uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (in_kind),
    .task_id_i    (in_task),
    .tick_amount_i(in_amount),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .result_kind_o(res_kind),
    .target_task_o(res_task),
    .time_value_o (res_time),
    .last_o       (res_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The receiver stalls at random. During a hold-off it stalls without a break,
  // so the output register stays full and the next result blocks the input.
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Every result accepted at this edge is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(res_kind, res_task, res_time, res_last);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // This task offers one item and returns at the edge that accepts it. Valid
  // stays high into the next item unless the sender decides to idle, and the
  // payload changes only after an acceptance.
  task automatic send_item(input kind_e kind, input logic [TASK_W-1:0] tid,
                           input logic signed [DL_W-1:0] amount);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_task <= tid;
    in_amount <= amount;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_item(kind, tid, amount);
  endtask

  // This task puts a delay on a wake tick at a given distance from the current
  // count, as an absolute deadline or as a relative amount.
  task automatic sleep_for(input logic [TASK_W-1:0] tid, input int offset, input logic absolute);
    if (absolute) send_item(KIND_ABS, tid, int'(tracker.now_count) + offset);
    else send_item(KIND_REL, tid, offset);
  endtask

  // Most items are near the current count, so tasks really sleep and wake.
  // The rest carry random 32-bit amounts or the extremes of the range.
  task automatic send_random_item();
    int pick;
    int spread;
    logic [TASK_W-1:0] tid;
    logic signed [DL_W-1:0] amount;
    pick = $urandom_range(99);
    spread = $urandom_range(99);
    tid = TASK_W'($urandom_range(SLOTS - 1));
    if (spread < 80) amount = $signed(DL_W'($urandom_range(12))) - 3;
    else if (spread < 92) amount = $urandom();
    else if (spread < 96) amount = DL_MAX;
    else amount = DL_MIN;
    if (pick < 22) begin
      send_item(KIND_QUERY, tid, $urandom());
    end else if (pick < 50) begin
      send_item(KIND_REL, tid, amount);
    end else if (pick < 72) begin
      if (spread < 80) amount = amount + int'(tracker.now_count);
      send_item(KIND_ABS, tid, amount);
    end else begin
      send_item(KIND_TICK, tid, $urandom());
    end
  endtask

  // The sender goes quiet until every predicted result has been received.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (tracker.count() != 0) @(posedge clk);
  endtask

  initial begin
    int perm [SLOTS];
    int pick;
    int swap;
    int drain;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // The directed part starts with time queries from the lowest and highest task.
    send_item(KIND_QUERY, 5'd0, 32'sd0);
    send_item(KIND_QUERY, 5'd31, DL_MIN);
    send_item(KIND_TICK, 5'd31, DL_MAX);
    // A deadline at the current count or in the past wakes the task at once.
    send_item(KIND_REL, 5'd3, 32'sd0);
    send_item(KIND_REL, 5'd4, -32'sd5);
    send_item(KIND_ABS, 5'd5, DL_MIN);
    send_item(KIND_REL, 5'd8, DL_MIN);
    // An absolute deadline at the top of the range sleeps for good, and a
    // relative one from a nonzero count saturates to the same value.
    send_item(KIND_ABS, 5'd6, DL_MAX);
    send_item(KIND_REL, 5'd7, DL_MAX);
    // Equal deadlines wake in insertion order. A repeat request moves task 9
    // to an earlier deadline and makes it the newest entry.
    sleep_for(5'd9, 2, 1'b1);
    sleep_for(5'd10, 2, 1'b1);
    sleep_for(5'd11, 2, 1'b1);
    sleep_for(5'd12, 1, 1'b1);
    sleep_for(5'd9, 1, 1'b0);
    send_item(KIND_TICK, 5'd0, 32'sd0);
    send_item(KIND_QUERY, 5'd17, 32'sd0);
    send_item(KIND_TICK, 5'd0, 32'sd0);
    // Repeat requests pull the two saturated sleepers back to due deadlines.
    sleep_for(5'd6, 0, 1'b1);
    sleep_for(5'd7, -1, 1'b0);
    pause_until_drained();

    // Every slot is filled with the same wake tick while the receiver holds
    // off, so the queries back up in the block. The tick then wakes all of
    // them in one item, which is the largest burst one item can cause.
    hold_off <= 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    for (int i = 0; i < SLOTS; i++) perm[i] = i;
    for (int i = SLOTS - 1; i > 0; i--) begin
      pick = $urandom_range(i);
      swap = perm[i];
      perm[i] = perm[pick];
      perm[pick] = swap;
    end
    for (int i = 0; i < SLOTS; i++) sleep_for(TASK_W'(perm[i]), 1, 1'($urandom_range(1)));
    repeat (4) send_item(KIND_QUERY, TASK_W'($urandom_range(SLOTS - 1)), $urandom());
    send_item(KIND_TICK, 5'd0, 32'sd0);
    pause_until_drained();

    // The random part runs in three phases: first the receiver stalls often,
    // then the sender idles often, and at last neither of them pauses.
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          idle_pct = 11;
          stall_pct <= 58;
        end
        1: begin
          idle_pct = 58;
          stall_pct <= 11;
        end
        default: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
      endcase
      repeat (75) send_random_item();
      pause_until_drained();
    end

    drain = 0;
    while (tracker.count() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    tracker.close();
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
